### sv/pgmh_pkg.sv
package pgmh_pkg;

	// Default bit count of the largest accepted width or height
	localparam int DIM_BITS_DEF = 16;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_BAD_MAGIC = 3'd0;
	localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
	localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
	localparam logic [2:0] ERR_BAD_SIZE  = 3'd3;
	localparam logic [2:0] ERR_BAD_MAX   = 3'd4;
	localparam logic [2:0] ERR_TOO_LARGE = 3'd5;

	// Characters
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] MAX_GREY = 8'hFF;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  max_value;
		logic [7:0]  pixel;
		logic        last;
		logic [2:0]  err;
	} pgmh_result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

### sv/pgmh_core.sv
module pgmh_core #(
	parameter int DIM_BITS = pgmh_pkg::DIM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  file_start,
	output logic                  res_valid,
	output pgmh_pkg::pgmh_result_t res
);
	import pgmh_pkg::*;

	localparam int AW = DIM_BITS + 1;
	localparam int PW = DIM_BITS + 5;
	localparam logic [AW-1:0] SAT = {1'b1, {DIM_BITS{1'b0}}};

	// Parse phases
	localparam logic [3:0] PH_MAGIC_P = 4'd0;
	localparam logic [3:0] PH_MAGIC_5 = 4'd1;
	localparam logic [3:0] PH_SKIP_W  = 4'd2;
	localparam logic [3:0] PH_NUM_W   = 4'd3;
	localparam logic [3:0] PH_SKIP_H  = 4'd4;
	localparam logic [3:0] PH_NUM_H   = 4'd5;
	localparam logic [3:0] PH_SKIP_M  = 4'd6;
	localparam logic [3:0] PH_NUM_M   = 4'd7;
	localparam logic [3:0] PH_PIXELS  = 4'd8;
	localparam logic [3:0] PH_IDLE    = 4'd9;

	logic [3:0]          phase_q, phase_n, ph_cur, skip_ph;
	logic                in_comment_q, in_comment_n, incom;
	logic [AW-1:0]       accum_q, accum_n, acc_mac, num_val;
	logic                negative_q, negative_n;
	logic                digit_seen_q, digit_seen_n;
	logic [AW-1:0]       width_q, width_n, height_q, height_n;
	logic [DIM_BITS-1:0] column_q, column_n, row_q, row_n;
	logic [3:0]          dval;
	logic [PW-1:0]       prod;
	logic [31:0]         w_ext, h_ext;
	logic                do_skip;

	// A file start restarts the parse at the first magic byte
	assign ph_cur = file_start ? PH_MAGIC_P : phase_q;

	// Multiply by ten and add the digit, saturating one above the limit
	assign dval    = 4'(data_byte - CH_ZERO);
	assign prod    = (PW'(accum_q) << 3) + (PW'(accum_q) << 1) + PW'(dval);
	assign acc_mac = (prod > PW'(SAT)) ? SAT : prod[AW-1:0];
	assign num_val = negative_q ? '0 : accum_q;
	assign w_ext   = 32'(width_q);
	assign h_ext   = 32'(height_q);

	// Next state and result for one byte
	always_comb begin
		phase_n      = ph_cur;
		in_comment_n = in_comment_q;
		accum_n      = accum_q;
		negative_n   = negative_q;
		digit_seen_n = digit_seen_q;
		width_n      = width_q;
		height_n     = height_q;
		column_n     = column_q;
		row_n        = row_q;
		res_valid    = 1'b0;
		res          = '0;
		do_skip      = 1'b0;
		skip_ph      = ph_cur;
		incom        = in_comment_q;

		case (ph_cur)
			PH_MAGIC_P: begin
				if (data_byte != CH_P) begin
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					res.err   = ERR_BAD_MAGIC;
				end else begin
					phase_n = PH_MAGIC_5;
				end
			end
			PH_MAGIC_5: begin
				if (data_byte != CH_FIVE) begin
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					res.err   = ERR_BAD_MAGIC;
				end else begin
					in_comment_n = 1'b0;
					phase_n      = PH_SKIP_W;
				end
			end
			PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
				do_skip = 1'b1;
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
				if (is_digit(data_byte)) begin
					accum_n      = acc_mac;
					digit_seen_n = 1'b1;
				end else if (!digit_seen_q) begin
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					res.err   = ERR_NO_DIGITS;
				end else if (ph_cur == PH_NUM_W) begin
					width_n      = num_val;
					in_comment_n = 1'b0;
					incom        = 1'b0;
					do_skip      = 1'b1;
					skip_ph      = PH_SKIP_H;
				end else if (ph_cur == PH_NUM_H) begin
					height_n     = num_val;
					in_comment_n = 1'b0;
					incom        = 1'b0;
					do_skip      = 1'b1;
					skip_ph      = PH_SKIP_M;
				end else begin
					// Trailing byte after the maximum: run the checks in order
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					if (!is_ws(data_byte)) begin
						res.err = ERR_NO_SPACE;
					end else if ((width_q == '0) || (height_q == '0)) begin
						res.err = ERR_BAD_SIZE;
					end else if (width_q[DIM_BITS] || height_q[DIM_BITS]) begin
						res.err = ERR_TOO_LARGE;
					end else if ((num_val == '0) || (num_val > AW'(MAX_GREY))) begin
						res.err = ERR_BAD_MAX;
					end else begin
						column_n      = '0;
						row_n         = '0;
						phase_n       = PH_PIXELS;
						res.kind      = KIND_HEADER;
						res.width     = w_ext[15:0];
						res.height    = h_ext[15:0];
						res.max_value = num_val[7:0];
					end
				end
			end
			PH_PIXELS: begin
				res_valid = 1'b1;
				res.kind  = KIND_PIXEL;
				res.pixel = data_byte;
				if ((AW'(column_q) + AW'(1)) >= width_q) begin
					column_n = '0;
					if ((AW'(row_q) + AW'(1)) >= height_q) begin
						res.last = 1'b1;
						phase_n  = PH_IDLE;
					end else begin
						row_n = row_q + DIM_BITS'(1);
					end
				end else begin
					column_n = column_q + DIM_BITS'(1);
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// Skip whitespace and comments, then open the next number
		if (do_skip) begin
			phase_n = skip_ph;
			if (incom) begin
				if (data_byte == CH_LF) in_comment_n = 1'b0;
			end else if (data_byte == CH_HASH) begin
				in_comment_n = 1'b1;
			end else if (!is_ws(data_byte)) begin
				accum_n      = '0;
				negative_n   = 1'b0;
				digit_seen_n = 1'b0;
				if ((data_byte == CH_PLUS) || (data_byte == CH_MINUS)) begin
					negative_n = (data_byte == CH_MINUS);
					phase_n    = skip_ph + 4'd1;
				end else if (is_digit(data_byte)) begin
					accum_n      = AW'(dval);
					digit_seen_n = 1'b1;
					phase_n      = skip_ph + 4'd1;
				end else begin
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					res.err   = ERR_NO_DIGITS;
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC_P;
			in_comment_q <= 1'b0;
			negative_q   <= 1'b0;
			digit_seen_q <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_n;
			in_comment_q <= in_comment_n;
			negative_q   <= negative_n;
			digit_seen_q <= digit_seen_n;
		end
	end

	// Number and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			column_q <= '0;
			row_q    <= '0;
		end else if (step) begin
			accum_q  <= accum_n;
			width_q  <= width_n;
			height_q <= height_n;
			column_q <= column_n;
			row_q    <= row_n;
		end
	end

endmodule

### sv/pgm_binary_header_parser_top.sv
// Binary grey image header parser.
// Input channel s_axis: one file byte per item in tdata, tuser set on the
// first byte of a new file, which restarts the parse from the magic bytes.
// Output channel m_axis: at most one result per input byte. tuser gives the
// kind (header, pixel, error); a header carries width, height and maximum,
// a pixel item carries the byte with tlast on the last pixel of the image,
// an error item carries its code. Bytes that only advance the parse (magic,
// whitespace, comments, digits) give no result; after an error or the last
// pixel, bytes are dropped until the next file start.
// Each byte is held in the input register, and its result is then loaded
// into the result register that drives m_axis. Throughput: one byte per
// cycle while no result stalls in the output; the per-byte work is a phase
// update and one multiply-by-ten accumulate.
// Reset: the parser waits for the magic 'P' even without a file start, and
// both registers are emptied.
// Stall: while a result waits in the output register one more byte is held
// in the input register; s_axis_tready then drops until m_axis_tready rises.
module pgm_binary_header_parser_top #(
	parameter int DIM_BITS = pgmh_pkg::DIM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] image_width, [31:16] image_height, [39:32] max_value,
	// [47:40] pixel, [50:48] error_code, [55:51] zero
	output logic [55:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
	output logic        m_axis_tlast    // last_pixel
);
	import pgmh_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	logic         advance;
	logic         res_valid;
	pgmh_result_t res;
	logic         out_valid_q;
	pgmh_result_t out_q;

	// Process the held byte when the result register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	pgmh_core #(
		.DIM_BITS(DIM_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.file_start (start_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.err, out_q.pixel, out_q.max_value,
		out_q.height, out_q.width};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule

### sv/pgmh_checker.sv
module pgmh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import pgmh_pkg::*;

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Only pixel items carry tlast
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PIXEL)
		else $error("tlast on a non-pixel item");

	// Pixel items leave header and error fields zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_PIXEL |->
		m_axis_tdata[39:0] == 40'd0 && m_axis_tdata[55:48] == 8'd0)
		else $error("pixel item with stray fields");

	// Error items carry a known code and nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
		m_axis_tdata[50:48] <= ERR_TOO_LARGE && m_axis_tdata[47:0] == 48'd0)
		else $error("malformed error item");

	// A header reports a nonzero maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_HEADER |->
		m_axis_tdata[39:32] != 8'd0 && !m_axis_tlast)
		else $error("header with zero maximum");

endmodule

bind pgm_binary_header_parser_top pgmh_checker u_pgmh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

### tb/tb_pgm_binary_header_parser_top.sv
`timescale 1ns / 100ps

module tb_pgm_binary_header_parser_top;

	import pgmh_pkg::*;

	localparam int unsigned DIM_LIMIT    = (1 << DIM_BITS_DEF) - 1;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned RANDOM_ITEMS = 550;
	localparam int unsigned TAIL_CYCLES  = 20;

	// Sign in front of a number
	localparam int SIGN_NONE  = 0;
	localparam int SIGN_PLUS  = 1;
	localparam int SIGN_MINUS = 2;

	// Kinds of damage done to a generated file
	localparam int FLAW_NONE   = 0;
	localparam int FLAW_MAGIC  = 1;
	localparam int FLAW_DIGITS = 2;
	localparam int FLAW_SPACE  = 3;
	localparam int FLAW_SIZE   = 4;
	localparam int FLAW_LARGE  = 5;
	localparam int FLAW_MAX    = 6;
	localparam int FLAW_CUT    = 7;
	localparam int FLAW_HUGE   = 8;
	localparam int FLAW_NOISE  = 9;

	typedef enum logic [3:0] {
		ST_WAIT_P, ST_WAIT_5, ST_SKIP_W, ST_NUM_W, ST_SKIP_H,
		ST_NUM_H, ST_SKIP_M, ST_NUM_M, ST_PIXELS, ST_IDLE
	} parse_state_e;

	// Header parser mirror and queue of the results it still owes
	class pgm_header_scoreboard;
		parse_state_e state;
		bit in_comment;
		int unsigned accum;
		bit negative;
		bit digit_seen;
		int unsigned width;
		int unsigned height;
		int unsigned grey_max;
		int unsigned column;
		int unsigned row;
		pgmh_result_t pending_results[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		static function bit is_white(logic [7:0] c);
			return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		static function bit is_dec(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function void restart();
			state = ST_WAIT_P;
			in_comment = 1'b0;
			accum = 0;
			negative = 1'b0;
			digit_seen = 1'b0;
			width = 0;
			height = 0;
			grey_max = 0;
			column = 0;
			row = 0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		function void push_result(logic [1:0] kind, int unsigned w, int unsigned h,
				int unsigned mx, logic [7:0] px, logic last, logic [2:0] code);
			pgmh_result_t r;
			r.kind = kind;
			r.width = w[15:0];
			r.height = h[15:0];
			r.max_value = mx[7:0];
			r.pixel = px;
			r.last = last;
			r.err = code;
			pending_results.push_back(r);
		endfunction

		function void abort_parse(logic [2:0] code);
			state = ST_IDLE;
			push_result(KIND_ERROR, 0, 0, 0, 8'h00, 1'b0, code);
		endfunction

		function int unsigned number_value();
			return negative ? 0 : accum;
		endfunction

		// Whitespace and comments before a number, then its first byte
		function void skip_char(logic [7:0] c, parse_state_e skip_st, parse_state_e num_st);
			state = skip_st;
			if (in_comment) begin
				if (c == CH_LF)
					in_comment = 1'b0;
				return;
			end
			if (c == CH_HASH) begin
				in_comment = 1'b1;
				return;
			end
			if (is_white(c))
				return;
			accum = 0;
			negative = 1'b0;
			digit_seen = 1'b0;
			if (c == CH_PLUS || c == CH_MINUS) begin
				negative = (c == CH_MINUS);
				state = num_st;
			end else if (is_dec(c)) begin
				accum = c - CH_ZERO;
				digit_seen = 1'b1;
				state = num_st;
			end else begin
				abort_parse(ERR_NO_DIGITS);
			end
		endfunction

		// Advance the parse by one accepted byte; return 0 if the byte was dropped
		function bit accept_byte(logic [7:0] c, logic file_start);
			int unsigned mx;
			bit used;
			used = file_start || state != ST_IDLE;
			if (file_start)
				restart();
			case (state)
				ST_WAIT_P: begin
					if (c != CH_P)
						abort_parse(ERR_BAD_MAGIC);
					else
						state = ST_WAIT_5;
				end
				ST_WAIT_5: begin
					if (c != CH_FIVE) begin
						abort_parse(ERR_BAD_MAGIC);
					end else begin
						in_comment = 1'b0;
						state = ST_SKIP_W;
					end
				end
				ST_SKIP_W: skip_char(c, ST_SKIP_W, ST_NUM_W);
				ST_SKIP_H: skip_char(c, ST_SKIP_H, ST_NUM_H);
				ST_SKIP_M: skip_char(c, ST_SKIP_M, ST_NUM_M);
				ST_NUM_W, ST_NUM_H, ST_NUM_M: begin
					if (is_dec(c)) begin
						accum = accum * 10 + (c - CH_ZERO);
						if (accum > DIM_LIMIT + 1)
							accum = DIM_LIMIT + 1;
						digit_seen = 1'b1;
					end else if (!digit_seen) begin
						abort_parse(ERR_NO_DIGITS);
					end else if (state == ST_NUM_W) begin
						width = number_value();
						in_comment = 1'b0;
						skip_char(c, ST_SKIP_H, ST_NUM_H);
					end else if (state == ST_NUM_H) begin
						height = number_value();
						in_comment = 1'b0;
						skip_char(c, ST_SKIP_M, ST_NUM_M);
					end else begin
						// Trailing byte: checks in fixed priority
						mx = number_value();
						if (!is_white(c))
							abort_parse(ERR_NO_SPACE);
						else if (width < 1 || height < 1)
							abort_parse(ERR_BAD_SIZE);
						else if (width > DIM_LIMIT || height > DIM_LIMIT)
							abort_parse(ERR_TOO_LARGE);
						else if (mx < 1 || mx > MAX_GREY)
							abort_parse(ERR_BAD_MAX);
						else begin
							grey_max = mx;
							column = 0;
							row = 0;
							state = ST_PIXELS;
							push_result(KIND_HEADER, width, height, grey_max, 8'h00, 1'b0,
								ERR_BAD_MAGIC);
						end
					end
				end
				ST_PIXELS: begin
					if (column + 1 >= width) begin
						column = 0;
						if (row + 1 >= height) begin
							state = ST_IDLE;
							push_result(KIND_PIXEL, 0, 0, 0, c, 1'b1, ERR_BAD_MAGIC);
						end else begin
							row = row + 1;
							push_result(KIND_PIXEL, 0, 0, 0, c, 1'b0, ERR_BAD_MAGIC);
						end
					end else begin
						column = column + 1;
						push_result(KIND_PIXEL, 0, 0, 0, c, 1'b0, ERR_BAD_MAGIC);
					end
				end
				default: state = ST_IDLE;
			endcase
			return used;
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH: %s", msg);
		endtask

		// Compare one output item with the oldest prediction
		task check_result(logic [1:0] kind, logic [55:0] data, logic last);
			pgmh_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result, kind %0d data %h", kind, data));
				return;
			end
			want = pending_results.pop_front();
			if (kind != want.kind)
				report($sformatf("kind %0d, want %0d", kind, want.kind));
			if (data[15:0] != want.width)
				report($sformatf("width %0d, want %0d", data[15:0], want.width));
			if (data[31:16] != want.height)
				report($sformatf("height %0d, want %0d", data[31:16], want.height));
			if (data[39:32] != want.max_value)
				report($sformatf("max %0d, want %0d", data[39:32], want.max_value));
			if (data[47:40] != want.pixel)
				report($sformatf("pixel %h, want %h", data[47:40], want.pixel));
			if (data[50:48] != want.err)
				report($sformatf("error code %0d, want %0d", data[50:48], want.err));
			if (data[55:51] != 5'd0)
				report($sformatf("padding bits %b not zero", data[55:51]));
			if (last != want.last)
				report($sformatf("tlast %b, want %b", last, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	pgm_header_scoreboard sb = new();
	logic [7:0] file_bytes[$];
	int unsigned bytes_used = 0;
	int unsigned cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	pgm_binary_header_parser_top #(
		.DIM_BITS(DIM_BITS_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Stall the result side at random and check every accepted item
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void put(logic [7:0] c);
		file_bytes.push_back(c);
	endfunction

	function automatic void put_text(string s);
		foreach (s[i])
			put(s[i]);
	endfunction

	function automatic logic [7:0] ws_char();
		return ($urandom_range(5) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(4));
	endfunction

	// Byte that is neither whitespace, digit, sign nor comment mark
	function automatic logic [7:0] odd_char();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (pgm_header_scoreboard::is_white(c) || pgm_header_scoreboard::is_dec(c) ||
			c == CH_HASH || c == CH_PLUS || c == CH_MINUS);
		return c;
	endfunction

	// Whitespace and comments between numbers
	function automatic void put_gap(bit allow_empty);
		logic [7:0] c;
		repeat ($urandom_range(allow_empty ? 0 : 1, 3)) begin
			if ($urandom_range(3) == 0) begin
				put(CH_HASH);
				repeat ($urandom_range(4)) begin
					c = 8'($urandom);
					put((c == CH_LF) ? 8'h2E : c);
				end
				put(CH_LF);
			end else begin
				put(ws_char());
			end
		end
	endfunction

	// Decimal number with optional sign and leading zeros, or a malformed start
	function automatic void put_field(int unsigned v, int sign, bit broken);
		string s;
		if (broken) begin
			if ($urandom_range(1))
				put(($urandom_range(1) != 0) ? CH_PLUS : CH_MINUS);
			put(odd_char());
			return;
		end
		s = $sformatf("%0d", v);
		if (sign == SIGN_PLUS)
			put(CH_PLUS);
		else if (sign == SIGN_MINUS)
			put(CH_MINUS);
		repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)
			put(CH_ZERO);
		foreach (s[i])
			put(s[i]);
	endfunction

	// Build one file, mostly well formed, sometimes damaged in one place
	function automatic void build_file();
		int unsigned dim [2];
		int unsigned grey;
		int dim_sign [2];
		int grey_sign;
		int flaw;
		int spot;
		logic [7:0] c;
		flaw = ($urandom_range(99) < 65) ? FLAW_NONE : $urandom_range(FLAW_MAGIC, FLAW_NOISE);
		spot = $urandom_range(2);
		dim[0] = $urandom_range(1, 6);
		dim[1] = $urandom_range(1, 4);
		grey = $urandom_range(1, 255);
		dim_sign[0] = ($urandom_range(4) == 0) ? SIGN_PLUS : SIGN_NONE;
		dim_sign[1] = ($urandom_range(4) == 0) ? SIGN_PLUS : SIGN_NONE;
		grey_sign = ($urandom_range(4) == 0) ? SIGN_PLUS : SIGN_NONE;
		case (flaw)
			FLAW_MAGIC: begin
				if ($urandom_range(1)) begin
					do c = 8'($urandom); while (c == CH_P);
					put(c);
				end else begin
					put(CH_P);
					do c = 8'($urandom); while (c == CH_FIVE);
					put(c);
				end
				repeat ($urandom_range(3))
					put(8'($urandom));
				return;
			end
			FLAW_NOISE: begin
				put(CH_P);
				put(CH_FIVE);
				repeat ($urandom_range(1, 10))
					put(8'($urandom));
				return;
			end
			FLAW_SIZE: begin
				if ($urandom_range(1))
					dim[spot % 2] = 0;
				else
					dim_sign[spot % 2] = SIGN_MINUS;
			end
			FLAW_LARGE: begin
				dim[spot % 2] = ($urandom_range(1) != 0) ? $urandom_range(65536, 70000) :
					$urandom_range(100000, 32'hFFFF_FFFF);
			end
			FLAW_MAX: begin
				case ($urandom_range(2))
					0: grey = 0;
					1: grey = $urandom_range(256, 99999);
					default: begin
						grey = $urandom_range(9);
						grey_sign = SIGN_MINUS;
					end
				endcase
			end
			FLAW_HUGE: begin
				if (spot != 1)
					dim[0] = DIM_LIMIT;
				if (spot != 0)
					dim[1] = DIM_LIMIT;
			end
			default: ;
		endcase
		put(CH_P);
		put(CH_FIVE);
		put_gap(1'b1);
		put_field(dim[0], dim_sign[0], flaw == FLAW_DIGITS && spot == 0);
		put_gap(dim_sign[1] != SIGN_NONE);
		put_field(dim[1], dim_sign[1], flaw == FLAW_DIGITS && spot == 1);
		put_gap(grey_sign != SIGN_NONE);
		put_field(grey, grey_sign, flaw == FLAW_DIGITS && spot == 2);
		if (flaw == FLAW_SPACE)
			put(($urandom_range(2) == 0) ? CH_HASH : odd_char());
		else
			put(ws_char());
		// Cut the header short; the next file restarts the parse if sent with a file start
		if (flaw == FLAW_CUT) begin
			file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 2)];
			return;
		end
		if (flaw == FLAW_NONE) begin
			repeat (dim[0] * dim[1])
				put(8'($urandom));
		end else if (flaw == FLAW_HUGE) begin
			repeat ($urandom_range(1, 6))
				put(8'($urandom));
		end
		// Trailing bytes that the block should drop or take as pixels
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3))
				put(8'($urandom));
		end
	endfunction

	// Offer one byte after a random gap and wait for the handshake
	task automatic send_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= start;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (sb.accept_byte(b, start))
			bytes_used++;
	endtask

	task automatic send_file(input bit with_start);
		foreach (file_bytes[i])
			send_byte(file_bytes[i], with_start && i == 0);
		file_bytes.delete();
	endtask

	// Hold the input side until every predicted result has come out
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		int unsigned first_random;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest image right after reset without a file start, all-ones pixel
		put_text("P51 1 255\n");
		put(MAX_GREY);
		send_file(1'b0);
		// Bad magic, then negative height after a comment
		put_text("Q");
		send_file(1'b1);
		put_text("P5#x\n2\t-1 7\n");
		send_file(1'b1);
		hold_until_drained();

		// Random files under four idling patterns
		first_random = bytes_used;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 88; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 88; end
				default: begin gap_pct = 6; stall_pct = 6; end
			endcase
			while (bytes_used < first_random + RANDOM_ITEMS * (ph + 1) / 4) begin
				build_file();
				send_file($urandom_range(9) != 0);
			end
			hold_until_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never came", sb.pending()));
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
sv/pgmh_pkg.sv
sv/pgmh_core.sv
sv/pgm_binary_header_parser_top.sv
sv/pgmh_checker.sv
tb/tb_pgm_binary_header_parser_top.sv
